// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file of this project.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHK_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/s4acl_pkg.sv =====
// Package for the SOCKS4 request parser with permit list: sizes, codes and types.
// No dependencies; imported by the top level, cell and reply modules.
package s4acl_pkg;

    localparam int RULES   = 16;
    localparam int CNT_W   = $clog2(RULES + 1);
    localparam int PADDR_W = 3;

    localparam logic [7:0]  SOCKS_VER     = 8'h04;
    localparam logic [7:0]  CMD_CONNECT   = 8'h01;
    localparam logic [7:0]  CMD_BIND      = 8'h02;
    localparam logic [7:0]  REP_VN        = 8'h00;
    localparam logic [7:0]  REP_GRANT     = 8'h5A;
    localparam logic [7:0]  REP_REJECT    = 8'h5B;
    localparam logic [15:0] BIND_PORT_RST = 16'd12345;

    // Register index, taken from paddr[2].
    localparam logic REG_BIND_PORT = 1'b0;

    typedef enum logic [1:0] {
        FUNC_ADD   = 2'd0,
        FUNC_CLEAR = 2'd1,
        FUNC_REQ   = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_LOAD
    } t_state;

    typedef struct packed {
        logic            is_bind;
        logic [3:0][7:0] oct;      // oct[3] most significant
    } t_rule;

    // Search token that walks the cell row, one cell per cycle.
    typedef struct packed {
        logic             valid;
        logic             is_bind;
        logic [31:0]      addr;
        logic [CNT_W-1:0] remain;  // rules still to be checked
        logic             hit;
    } t_tok;

    typedef struct packed {
        logic        hit;
        logic [63:0] bytes;        // first reply byte in the top bits
    } t_reply;

endpackage

// ===== sv/socks4_request_acl_reply.sv =====
// Top level of the SOCKS4 request parser with an IP permit list.
// Depends on s4acl_pkg, s4acl_cell and s4acl_reply.
//
//  Channel | Role   | Payload
//  --------+--------+-------------------------------------------------------
//  s       | in     | tuser: func; tdata: rule_is_bind, rule_octet3..0, req_byte
//  m       | out    | tdata: reply_byte; tuser: granted; tlast: last
//  APB     | config | bind_port at byte address 0
//
// A rule operation, header byte or user ID byte is taken whenever the parser is idle.
// At the terminator of a valid request, a token walks the row of RULES cells,
// one cell per cycle; input is held off while the token walks and the reply loads,
// and also while the previous reply is still being sent.
// The 8 reply bytes drain from their own register while parsing continues;
// a later request waits only if the previous reply is still being sent.
// Reset is synchronous and active low; the rule cells need no clearing.
module socks4_request_acl_reply
    import s4acl_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    // [0] rule_is_bind, [8:1] rule_octet3, [16:9] rule_octet2,
    // [24:17] rule_octet1, [32:25] rule_octet0, [40:33] req_byte, rest zero
    input  logic [47:0]        i_s_tdata,
    // [1:0] func
    input  logic [1:0]         i_s_tuser,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    // [7:0] reply_byte
    output logic [7:0]         o_m_tdata,
    // [0] granted
    output logic               o_m_tuser,
    output logic               o_m_tlast,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_rule_count, n_rule_count;
    logic [3:0]       r_byte_pos, n_byte_pos;
    logic [63:0]      r_header, n_header;
    logic [15:0]      r_bind_port;
    logic             r_req_bind, n_req_bind;
    logic [15:0]      r_req_port, n_req_port;
    logic [31:0]      r_req_addr, n_req_addr;
    logic             r_hit, n_hit;

    logic             w_s_acc;
    logic             w_inject;
    logic             w_load;
    logic             w_reply_busy;
    logic [7:0]       w_req_byte;
    t_rule            w_rule;
    t_reply           w_reply;
    t_tok             w_tok [RULES+1];
    logic [RULES-1:0] w_wr_en;

    assign pready     = 1'b1;
    assign o_s_tready = (r_state == ST_IDLE);
    assign w_s_acc    = i_s_tvalid && o_s_tready;
    assign w_req_byte = i_s_tdata[40:33];

    assign w_rule.is_bind = i_s_tdata[0];
    assign w_rule.oct[3]  = i_s_tdata[8:1];
    assign w_rule.oct[2]  = i_s_tdata[16:9];
    assign w_rule.oct[1]  = i_s_tdata[24:17];
    assign w_rule.oct[0]  = i_s_tdata[32:25];

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_BIND_PORT) begin
            prdata = {16'h0000, r_bind_port};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bind_port <= BIND_PORT_RST;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_BIND_PORT) begin
            r_bind_port <= pwdata[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_rule_count <= '0;
            r_byte_pos   <= '0;
            r_header     <= '0;
        end else begin
            r_state      <= n_state;
            r_rule_count <= n_rule_count;
            r_byte_pos   <= n_byte_pos;
            r_header     <= n_header;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req_bind <= n_req_bind;
        r_req_port <= n_req_port;
        r_req_addr <= n_req_addr;
        r_hit      <= n_hit;
    end

    always_comb begin
        n_state      = r_state;
        n_rule_count = r_rule_count;
        n_byte_pos   = r_byte_pos;
        n_header     = r_header;
        n_req_bind   = r_req_bind;
        n_req_port   = r_req_port;
        n_req_addr   = r_req_addr;
        n_hit        = r_hit;
        w_inject     = 1'b0;
        w_load       = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_s_acc) begin
                    unique case (t_func'(i_s_tuser))
                        FUNC_ADD: begin
                            if (r_rule_count < CNT_W'(RULES)) begin
                                n_rule_count = r_rule_count + CNT_W'(1);
                            end
                        end
                        FUNC_CLEAR: begin
                            n_rule_count = '0;
                        end
                        FUNC_REQ: begin
                            if (r_byte_pos < 4'd8) begin
                                n_header   = {r_header[55:0], w_req_byte};
                                n_byte_pos = r_byte_pos + 4'd1;
                            end else if (w_req_byte == 8'h00) begin
                                n_header   = '0;
                                n_byte_pos = '0;
                                if (r_header[63:56] == SOCKS_VER &&
                                    (r_header[55:48] == CMD_CONNECT ||
                                     r_header[55:48] == CMD_BIND)) begin
                                    w_inject   = 1'b1;
                                    n_req_bind = (r_header[55:48] == CMD_BIND);
                                    n_req_port = r_header[47:32];
                                    n_req_addr = r_header[31:0];
                                    n_state    = ST_SEARCH;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SEARCH: begin
                if (w_tok[RULES].valid) begin
                    n_hit   = w_tok[RULES].hit;
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (!w_reply_busy) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // The token enters the first cell at the terminator and carries the rule count.
    assign w_tok[0].valid   = w_inject;
    assign w_tok[0].is_bind = (r_header[55:48] == CMD_BIND);
    assign w_tok[0].addr    = r_header[31:0];
    assign w_tok[0].remain  = r_rule_count;
    assign w_tok[0].hit     = 1'b0;

    for (genvar gi = 0; gi < RULES; gi++) begin : g_cell
        assign w_wr_en[gi] = w_s_acc && (t_func'(i_s_tuser) == FUNC_ADD) &&
                             (r_rule_count == CNT_W'(gi));

        s4acl_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_wr_en (w_wr_en[gi]),
            .i_rule  (w_rule),
            .i_tok   (w_tok[gi]),
            .o_tok   (w_tok[gi+1])
        );
    end

    always_comb begin
        w_reply.hit   = r_hit;
        w_reply.bytes = {REP_VN,
                         r_hit ? REP_GRANT : REP_REJECT,
                         r_req_bind ? r_bind_port : r_req_port,
                         r_req_bind ? 32'h0000_0000 : r_req_addr};
    end

    s4acl_reply u_reply (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_load),
        .i_reply    (w_reply),
        .o_busy     (w_reply_busy),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

// ===== sv/s4acl_cell.sv =====
// One permit-rule cell: holds a rule and checks the passing search token.
// Depends on s4acl_pkg.
module s4acl_cell
    import s4acl_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_wr_en,
    input  t_rule i_rule,
    input  t_tok  i_tok,
    output t_tok  o_tok
);

    t_rule r_rule;
    t_tok  r_tok;
    t_tok  n_tok;
    logic  w_match;

    always_comb begin
        w_match = (i_tok.remain != '0) && (r_rule.is_bind == i_tok.is_bind);
        for (int k = 0; k < 4; k++) begin
            if (r_rule.oct[k] != 8'h00 && r_rule.oct[k] != i_tok.addr[8*k +: 8]) begin
                w_match = 1'b0;
            end
        end
        n_tok = i_tok;
        n_tok.hit = i_tok.hit | w_match;
        if (i_tok.remain != '0) begin
            n_tok.remain = i_tok.remain - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_rule <= i_rule;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

// ===== sv/s4acl_reply.sv =====
// Reply serializer: holds one 8-byte reply and sends it a byte per transaction.
// Depends on s4acl_pkg.
module s4acl_reply
    import s4acl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_reply     i_reply,
    output logic       o_busy,
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,
    output logic       o_m_tuser,
    output logic       o_m_tlast
);

    logic        r_valid;
    logic [2:0]  r_cnt;
    logic [63:0] r_data;
    logic        r_hit;
    logic        w_take;

    assign w_take = r_valid && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else if (i_load && !r_valid) begin
            r_valid <= 1'b1;
            r_cnt   <= '0;
        end else if (w_take) begin
            r_cnt <= r_cnt + 3'd1;
            if (r_cnt == 3'd7) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && !r_valid) begin
            r_data <= i_reply.bytes;
            r_hit  <= i_reply.hit;
        end else if (w_take) begin
            r_data <= {r_data[55:0], 8'h00};
        end
    end

    assign o_busy     = r_valid;
    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_data[63:56];
    assign o_m_tuser  = r_hit;
    assign o_m_tlast  = (r_cnt == 3'd7);

endmodule

// ===== sv/s4acl_checker.sv =====
// Port-level checks for socks4_request_acl_reply, attached by bind.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module s4acl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [7:0]  o_m_tdata,
    input logic        o_m_tuser,
    input logic        o_m_tlast,
    input logic        psel,
    input logic        pready,
    input logic [31:0] prdata
);

    `CHK_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata))

    // A reply is sent without gaps and one grant flag covers all its bytes.
    `CHK_NEXT(a_reply_run, i_clk, i_rst_n, o_m_tvalid && i_m_tready && !o_m_tlast, o_m_tvalid && $stable(o_m_tuser))

    // The transaction right after a final byte can only open a new reply.
    `CHK_NEXT(a_reply_start, i_clk, i_rst_n, o_m_tvalid && i_m_tready && o_m_tlast, !o_m_tvalid || (o_m_tdata == 8'h00))

    `CHK_NOW(a_apb_read, i_clk, i_rst_n, psel, pready && (prdata[31:16] == 16'h0000))

endmodule

bind socks4_request_acl_reply s4acl_checker u_s4acl_checker (.*);
